// File: rtl/core/sfb_pkg.sv
// Shared types and constants for the SPI slave FIFO bridge.
package sfb_pkg;

    parameter int RX_DEPTH = 256;
    parameter int TX_DEPTH = 256;

    parameter int RX_PTR_W = $clog2(RX_DEPTH);
    parameter int TX_PTR_W = $clog2(TX_DEPTH);
    parameter int RX_CNT_W = $clog2(RX_DEPTH + 1);
    parameter int TX_CNT_W = $clog2(TX_DEPTH + 1);

    parameter int BYTE_W  = 8;
    parameter int LEVEL_W = 9;

    typedef enum logic [1:0] {
        KIND_MASTER = 2'd0,
        KIND_PUSH   = 2'd1,
        KIND_POP    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_OVERFLOW  = 1'b0,
        CFG_UNDERFLOW = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] wdata;
    } t_fifo_req;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [RX_CNT_W-1:0] count;
    } t_rx_stat;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [TX_CNT_W-1:0] count;
    } t_tx_stat;

endpackage

// File: rtl/core/spi_slave_fifo_bridge_core.sv
// Top level of the SPI slave FIFO bridge: command decode, result pipeline, interrupt.
//
// The input channel (i_valid / o_ready) carries one command beat: a byte from the
// SPI master (kind 0), a host push into the transmit FIFO (kind 1) or a host pop
// from the receive FIFO (kind 2). Kind 3 changes nothing and still yields a result.
// Every input beat produces exactly one result beat on the output channel
// (o_valid / i_ready) with the reply byte, the popped byte, the success flag, the
// receive FIFO fill and free space, and the interrupt level after the command.
// The two code registers are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// The FIFO RAMs are written and read at the accepting edge. The registered RAM
// read port sets the pending stage, which holds the beat until the output
// register is free or draining; the result is then loaded into the output register.
// Throughput: one beat per cycle while the output drains, since each beat does
// at most one push or one pop per FIFO and each RAM has its own write and read port.
// When the receiver stalls, the output register holds its beat and the pending
// stage holds the next one; o_ready then drops until the output drains.
// Reset (synchronous, active low) empties both FIFOs, clears the code registers
// and drops the interrupt line. No clearing pass is needed; the RAM contents are
// only read after being written.
module spi_slave_fifo_bridge_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic [sfb_pkg::BYTE_W-1:0]  i_data,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sfb_pkg::BYTE_W-1:0]  o_reply_byte,
    output logic [sfb_pkg::BYTE_W-1:0]  o_read_byte,
    output logic                        o_accepted,
    output logic [sfb_pkg::LEVEL_W-1:0] o_rx_fill,
    output logic [sfb_pkg::LEVEL_W-1:0] o_rx_free,
    output logic                        o_irq_level,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [sfb_pkg::BYTE_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [sfb_pkg::BYTE_W-1:0] r_ovf_code;
    logic [sfb_pkg::BYTE_W-1:0] r_unf_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_code <= '0;
            r_unf_code <= '0;
        end else if (i_cfg_we) begin
            unique case (sfb_pkg::t_cfg_idx'(i_cfg_idx))
                sfb_pkg::CFG_OVERFLOW:  r_ovf_code <= i_cfg_data;
                sfb_pkg::CFG_UNDERFLOW: r_unf_code <= i_cfg_data;
                default:                r_ovf_code <= r_ovf_code;
            endcase
        end
    end

    // FIFOs.
    sfb_pkg::t_fifo_req         rx_req;
    sfb_pkg::t_fifo_req         tx_req;
    sfb_pkg::t_rx_stat          rx_stat;
    sfb_pkg::t_tx_stat          tx_stat;
    logic [sfb_pkg::BYTE_W-1:0] rx_rdata;
    logic [sfb_pkg::BYTE_W-1:0] tx_rdata;

    sfb_rx_fifo u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .o_rdata (rx_rdata),
        .o_stat  (rx_stat)
    );

    sfb_tx_fifo u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .o_rdata (tx_rdata),
        .o_stat  (tx_stat)
    );

    // Pending stage: holds what the result needs while the RAM read completes.
    logic                       r_p_valid;
    logic                       r_p_use_tx;
    logic                       r_p_use_rx;
    logic                       r_p_acc;
    logic [sfb_pkg::BYTE_W-1:0] r_p_code;
    logic                       n_p_use_tx;
    logic                       n_p_use_rx;
    logic                       n_p_acc;
    logic [sfb_pkg::BYTE_W-1:0] n_p_code;

    // Output register.
    logic                        r_o_valid;
    logic [sfb_pkg::BYTE_W-1:0]  r_o_reply;
    logic [sfb_pkg::BYTE_W-1:0]  r_o_read;
    logic                        r_o_acc;
    logic [sfb_pkg::LEVEL_W-1:0] r_o_fill;
    logic [sfb_pkg::LEVEL_W-1:0] r_o_free;
    logic                        r_o_irq;

    logic r_irq, n_irq;
    logic in_acc;
    logic p_move;

    // The pending beat moves on when the output register is free or draining.
    assign p_move  = r_p_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_p_valid || p_move;
    assign in_acc  = i_valid && o_ready;

    // Command decode. Every FIFO access is issued at the accepting edge.
    always_comb begin
        rx_req       = '0;
        tx_req       = '0;
        rx_req.wdata = i_data;
        tx_req.wdata = i_data;
        n_irq        = r_irq;
        n_p_use_tx   = 1'b0;
        n_p_use_rx   = 1'b0;
        n_p_acc      = 1'b0;
        n_p_code     = '0;
        if (in_acc) begin
            unique case (sfb_pkg::t_kind'(i_kind))
                sfb_pkg::KIND_MASTER: begin
                    if (rx_stat.full) begin
                        // Overflow: the transmit side is left alone.
                        n_p_code = r_ovf_code;
                    end else begin
                        rx_req.push = 1'b1;
                        n_p_acc     = 1'b1;
                        if (tx_stat.empty) begin
                            n_p_code = r_unf_code;
                            n_irq    = 1'b0;
                        end else begin
                            tx_req.pop = 1'b1;
                            n_p_use_tx = 1'b1;
                        end
                    end
                end
                sfb_pkg::KIND_PUSH: begin
                    tx_req.push = 1'b1;
                    n_p_acc     = !tx_stat.full;
                    // The last beat of an array raises the line even if dropped.
                    if (i_last) begin
                        n_irq = 1'b1;
                    end
                end
                sfb_pkg::KIND_POP: begin
                    if (!rx_stat.empty) begin
                        rx_req.pop = 1'b1;
                        n_p_use_rx = 1'b1;
                        n_p_acc    = 1'b1;
                    end
                end
                sfb_pkg::KIND_NONE: begin
                    n_p_acc = 1'b0;
                end
                default: begin
                    n_p_acc = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq     <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_irq <= n_irq;
            if (in_acc) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_use_tx <= n_p_use_tx;
            r_p_use_rx <= n_p_use_rx;
            r_p_acc    <= n_p_acc;
            r_p_code   <= n_p_code;
        end
    end

    // The FIFO counts and the interrupt flag already reflect the pending beat,
    // and no later beat has reached them yet, so they are sampled here.
    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_reply <= r_p_use_tx ? tx_rdata : r_p_code;
            r_o_read  <= r_p_use_rx ? rx_rdata : '0;
            r_o_acc   <= r_p_acc;
            r_o_fill  <= sfb_pkg::LEVEL_W'(rx_stat.count);
            r_o_free  <= sfb_pkg::LEVEL_W'(sfb_pkg::RX_CNT_W'(sfb_pkg::RX_DEPTH) - rx_stat.count);
            r_o_irq   <= r_irq;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_reply_byte = r_o_reply;
    assign o_read_byte  = r_o_read;
    assign o_accepted   = r_o_acc;
    assign o_rx_fill    = r_o_fill;
    assign o_rx_free    = r_o_free;
    assign o_irq_level  = r_o_irq;

    // Every accepted beat lands in the pending stage.
    a_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_p_valid)
        else $error("accepted beat did not reach the pending stage");

    // The reported fill and free space always add up to the receive depth.
    a_rx_level_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((10'(o_rx_fill) + 10'(o_rx_free)) == 10'(sfb_pkg::RX_DEPTH)))
        else $error("receive fill and free do not add up to the depth");

    // The transmit count never exceeds its depth.
    a_tx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_stat.count <= sfb_pkg::TX_CNT_W'(sfb_pkg::TX_DEPTH))
        else $error("transmit count beyond depth");

    // The interrupt flag rises only after a host push marked last.
    a_irq_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq) |-> $past(in_acc && (i_kind == sfb_pkg::KIND_PUSH) && i_last))
        else $error("interrupt raised without a last push");

endmodule

// File: rtl/core/sfb_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module sfb_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sfb_rx_fifo.sv
// Receive FIFO: pointers, fill count and the backing RAM.
module sfb_rx_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfb_pkg::t_fifo_req        i_req,
    output logic [sfb_pkg::BYTE_W-1:0] o_rdata,
    output sfb_pkg::t_rx_stat         o_stat
);

    logic [sfb_pkg::RX_PTR_W-1:0] r_head, n_head;
    logic [sfb_pkg::RX_PTR_W-1:0] r_tail, n_tail;
    logic [sfb_pkg::RX_CNT_W-1:0] r_count, n_count;
    logic                         full;
    logic                         empty;
    logic                         push_ok;
    logic                         pop_ok;

    assign full    = (r_count == sfb_pkg::RX_CNT_W'(sfb_pkg::RX_DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = i_req.push && !full;
    assign pop_ok  = i_req.pop && !empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push_ok) begin
            n_tail = (r_tail == sfb_pkg::RX_PTR_W'(sfb_pkg::RX_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (pop_ok) begin
            n_head = (r_head == sfb_pkg::RX_PTR_W'(sfb_pkg::RX_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    sfb_ram #(
        .DEPTH (sfb_pkg::RX_DEPTH),
        .WIDTH (sfb_pkg::BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_tail),
        .i_wdata (i_req.wdata),
        .i_re    (pop_ok),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_stat.count = r_count;

endmodule

// File: rtl/core/sfb_tx_fifo.sv
// Transmit FIFO: pointers, fill count and the backing RAM.
module sfb_tx_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfb_pkg::t_fifo_req        i_req,
    output logic [sfb_pkg::BYTE_W-1:0] o_rdata,
    output sfb_pkg::t_tx_stat         o_stat
);

    logic [sfb_pkg::TX_PTR_W-1:0] r_head, n_head;
    logic [sfb_pkg::TX_PTR_W-1:0] r_tail, n_tail;
    logic [sfb_pkg::TX_CNT_W-1:0] r_count, n_count;
    logic                         full;
    logic                         empty;
    logic                         push_ok;
    logic                         pop_ok;

    assign full    = (r_count == sfb_pkg::TX_CNT_W'(sfb_pkg::TX_DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = i_req.push && !full;
    assign pop_ok  = i_req.pop && !empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push_ok) begin
            n_tail = (r_tail == sfb_pkg::TX_PTR_W'(sfb_pkg::TX_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (pop_ok) begin
            n_head = (r_head == sfb_pkg::TX_PTR_W'(sfb_pkg::TX_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    sfb_ram #(
        .DEPTH (sfb_pkg::TX_DEPTH),
        .WIDTH (sfb_pkg::BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_tail),
        .i_wdata (i_req.wdata),
        .i_re    (pop_ok),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_stat.count = r_count;

endmodule
